// ----- hw/rtl/adrtc_pkg.sv -----
// adrtc_pkg: shared types, codes and helper functions for the datetime to rtc register encoder
// no dependencies; imported by every module of the block
`default_nettype none
package adrtc_pkg;

	localparam int ADRTC_QUEUE_DEPTH = 2;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_TIME_DIGIT = 3'd1;
	localparam logic [2:0] ST_TIME_RANGE = 3'd2;
	localparam logic [2:0] ST_DATE_DIGIT = 3'd3;
	localparam logic [2:0] ST_YEAR_RANGE = 3'd4;
	localparam logic [2:0] ST_DAY_RANGE  = 3'd5;

	localparam logic [2:0] RA_SEC   = 3'd0;
	localparam logic [2:0] RA_MIN   = 3'd1;
	localparam logic [2:0] RA_HOUR  = 3'd2;
	localparam logic [2:0] RA_WDAY  = 3'd3;
	localparam logic [2:0] RA_DATE  = 3'd4;
	localparam logic [2:0] RA_MONTH = 3'd5;
	localparam logic [2:0] RA_YEAR  = 3'd6;

	localparam logic [13:0] YEAR_MIN = 14'd2000;
	localparam logic [13:0] YEAR_MAX = 14'd2099;
	localparam logic [6:0]  HOUR_MAX = 7'd23;
	localparam logic [6:0]  MINSEC_MAX = 7'd59;
	localparam logic [7:0]  SEC_MASK  = 8'h7F;
	localparam logic [7:0]  HOUR_MASK = 8'h3F;
	localparam logic [7:0]  CH_BIT_MASK = 8'h80;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} char_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] reg_addr;
		logic [7:0] reg_value;
		logic       last_of_run;
	} reg_req_t;

	// one finished command string, handed from parser to writer
	typedef struct packed {
		logic [2:0] status;
		logic       dated;
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hour;
		logic [6:0] year_ofs;
		logic [3:0] month;
		logic [4:0] day;
	} job_t;

	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		prod = 15'(v) * 15'd205;
		tens = prod[14:11];
		ones = v - 7'(tens) * 7'd10;
		return {tens, ones[3:0]};
	endfunction

	function automatic logic [2:0] month_offset(input logic [3:0] m);
		logic [2:0] r;
		case (m)
			4'd1:    r = 3'd0;
			4'd2:    r = 3'd3;
			4'd3:    r = 3'd2;
			4'd4:    r = 3'd5;
			4'd5:    r = 3'd0;
			4'd6:    r = 3'd3;
			4'd7:    r = 3'd5;
			4'd8:    r = 3'd1;
			4'd9:    r = 3'd4;
			4'd10:   r = 3'd6;
			4'd11:   r = 3'd2;
			4'd12:   r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/adrtc_front.sv -----
// adrtc_front: character parser; accumulates time and date digits, checks ranges
// depends on adrtc_pkg; emits one job per string into the queue
`default_nettype none
module adrtc_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    accept,
	input  adrtc_pkg::char_req_t   req,
	output logic                   push,
	output adrtc_pkg::job_t        job
);
	import adrtc_pkg::*;

	localparam logic [2:0] PH_LEAD     = 3'd0;
	localparam logic [2:0] PH_TIME     = 3'd1;
	localparam logic [2:0] PH_GAP      = 3'd2;
	localparam logic [2:0] PH_DATE     = 3'd3;
	localparam logic [2:0] PH_DATED    = 3'd4;
	localparam logic [2:0] PH_TIMEONLY = 3'd5;
	localparam logic [2:0] PH_ERR      = 3'd6;

	logic [2:0]  phase_q, phase_n;
	logic [2:0]  cnt_q, cnt_n;
	logic [2:0]  err_q, err_n;
	logic [6:0]  hour_q, hour_n, min_q, min_n, sec_q, sec_n;
	logic [6:0]  mon_q, mon_n, day_q, day_n;
	logic [13:0] year_q, year_n;
	logic        space, digit;
	logic [3:0]  v;
	logic [7:0]  c;

	function automatic logic [5:0] end_str(input logic [2:0] ph, input logic [2:0] er);
		logic [5:0] r;
		r = {ph, er};
		if (ph == PH_LEAD || ph == PH_TIME) begin
			r = {PH_ERR, ST_TIME_DIGIT};
		end else if (ph == PH_GAP) begin
			r = {PH_TIMEONLY, er};
		end else if (ph == PH_DATE) begin
			r = {PH_ERR, ST_DATE_DIGIT};
		end
		return r;
	endfunction

	assign c = req.char_code;
	assign space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	assign digit = (c >= 8'd48) && (c <= 8'd57);
	assign v = c[3:0];

	always_comb begin
		phase_n = phase_q;
		cnt_n = cnt_q;
		err_n = err_q;
		hour_n = hour_q;
		min_n = min_q;
		sec_n = sec_q;
		year_n = year_q;
		mon_n = mon_q;
		day_n = day_q;
		if (phase_q < PH_DATED) begin
			if (c == 8'd0) begin
				{phase_n, err_n} = end_str(phase_q, err_q);
			end else begin
				if (phase_n == PH_LEAD && !space) begin
					phase_n = PH_TIME;
				end
				if (phase_n == PH_TIME) begin
					if (!digit) begin
						phase_n = PH_ERR;
						err_n = ST_TIME_DIGIT;
					end else begin
						if (cnt_q < 3'd2) begin
							hour_n = 7'(hour_q * 7'd10 + 7'(v));
						end else if (cnt_q < 3'd4) begin
							min_n = 7'(min_q * 7'd10 + 7'(v));
						end else begin
							sec_n = 7'(sec_q * 7'd10 + 7'(v));
						end
						if (cnt_q == 3'd5) begin
							cnt_n = 3'd0;
							if (hour_n > HOUR_MAX || min_n > MINSEC_MAX || sec_n > MINSEC_MAX) begin
								phase_n = PH_ERR;
								err_n = ST_TIME_RANGE;
							end else begin
								phase_n = PH_GAP;
							end
						end else begin
							cnt_n = cnt_q + 3'd1;
						end
					end
				end else begin
					if (phase_n == PH_GAP && !space) begin
						phase_n = PH_DATE;
					end
					if (phase_n == PH_DATE) begin
						if (!digit) begin
							phase_n = PH_ERR;
							err_n = ST_DATE_DIGIT;
						end else begin
							if (cnt_q < 3'd4) begin
								year_n = 14'(year_q * 14'd10 + 14'(v));
							end else if (cnt_q < 3'd6) begin
								mon_n = 7'(mon_q * 7'd10 + 7'(v));
							end else begin
								day_n = 7'(day_q * 7'd10 + 7'(v));
							end
							if (cnt_q == 3'd7) begin
								cnt_n = 3'd0;
								if (year_n < YEAR_MIN || year_n > YEAR_MAX) begin
									phase_n = PH_ERR;
									err_n = ST_YEAR_RANGE;
								end else if (mon_n < 7'd1 || mon_n > 7'd12 ||
									day_n < 7'd1 || day_n > 7'd31) begin
									phase_n = PH_ERR;
									err_n = ST_DAY_RANGE;
								end else begin
									phase_n = PH_DATED;
								end
							end else begin
								cnt_n = cnt_q + 3'd1;
							end
						end
					end
				end
			end
		end
		if (req.is_last) begin
			{phase_n, err_n} = end_str(phase_n, err_n);
		end
	end

	assign push = accept && req.is_last;

	always_comb begin
		job.status   = (phase_n == PH_ERR) ? err_n : ST_OK;
		job.dated    = (phase_n == PH_DATED);
		job.sec      = sec_n[5:0];
		job.min      = min_n[5:0];
		job.hour     = hour_n[4:0];
		job.year_ofs = 7'(year_n - YEAR_MIN);
		job.month    = mon_n[3:0];
		job.day      = day_n[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			cnt_q <= '0;
			err_q <= '0;
			hour_q <= '0;
			min_q <= '0;
			sec_q <= '0;
			year_q <= '0;
			mon_q <= '0;
			day_q <= '0;
		end else if (push) begin
			phase_q <= PH_LEAD;
			cnt_q <= '0;
			err_q <= '0;
			hour_q <= '0;
			min_q <= '0;
			sec_q <= '0;
			year_q <= '0;
			mon_q <= '0;
			day_q <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q <= cnt_n;
			err_q <= err_n;
			hour_q <= hour_n;
			min_q <= min_n;
			sec_q <= sec_n;
			year_q <= year_n;
			mon_q <= mon_n;
			day_q <= day_n;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/adrtc_queue.sv -----
// adrtc_queue: small job fifo between parser and register writer
// depends on adrtc_pkg for the job type
`default_nettype none
module adrtc_queue #(
	parameter int DEPTH = adrtc_pkg::ADRTC_QUEUE_DEPTH
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  adrtc_pkg::job_t   push_job,
	input  wire               pop,
	output logic              full,
	output logic              not_empty,
	output adrtc_pkg::job_t   head
);
	import adrtc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= bump(wr_q);
			end
			if (do_pop) begin
				rd_q <= bump(rd_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/adrtc_back.sv -----
// adrtc_back: register writer; turns one job into bcd register write requests
// depends on adrtc_pkg; computes weekday on job load, one request per cycle out while out_stall is low
`default_nettype none
module adrtc_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   job_valid,
	input  adrtc_pkg::job_t       job,
	output logic                  pop,
	output logic                  out_valid,
	input  wire                   out_stall,
	output adrtc_pkg::reg_req_t   out_req
);
	import adrtc_pkg::*;

	logic       act_q;
	logic [2:0] idx_q;
	logic [2:0] status_q;
	logic       dated_q;
	logic [7:0] sec_q, min_q, hour_q, wday_q, date_q, mon_q, year_q;
	logic       out_valid_q;
	reg_req_t   out_q, item;
	logic       adv, emit, final_item, load;

	logic [6:0] t_y;
	logic [7:0] y_part, wsum;
	logic [4:0] f1;
	logic [3:0] f2;
	logic [2:0] wmod;

	// weekday from year offset, month, day
	always_comb begin
		t_y = (job.month < 4'd3) ? 7'(job.year_ofs - 7'd1) : job.year_ofs;
		if (job.month < 4'd3 && job.year_ofs == 7'd0) begin
			y_part = 8'd5;
		end else begin
			y_part = 8'(t_y) + 8'(t_y[6:2]);
		end
		wsum = y_part + 8'(month_offset(job.month)) + 8'(job.day);
		f1 = 5'(wsum[7:3]) + 5'(wsum[2:0]);
		f2 = 4'(f1[4:3]) + 4'(f1[2:0]);
		wmod = (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
	end

	always_comb begin
		if (status_q != ST_OK) begin
			final_item = 1'b1;
		end else if (dated_q) begin
			final_item = (idx_q == RA_YEAR);
		end else begin
			final_item = (idx_q == RA_HOUR);
		end
	end

	always_comb begin
		item.status = status_q;
		item.reg_addr = idx_q;
		item.last_of_run = final_item;
		if (status_q != ST_OK) begin
			item.reg_value = 8'd0;
		end else begin
			case (idx_q)
				RA_SEC:   item.reg_value = sec_q & SEC_MASK;
				RA_MIN:   item.reg_value = min_q;
				RA_HOUR:  item.reg_value = hour_q & HOUR_MASK;
				RA_WDAY:  item.reg_value = wday_q;
				RA_DATE:  item.reg_value = date_q;
				RA_MONTH: item.reg_value = mon_q;
				RA_YEAR:  item.reg_value = year_q;
				default:  item.reg_value = 8'd0;
			endcase
		end
	end

	assign adv = !out_valid_q || !out_stall;
	assign emit = adv && act_q;
	assign load = job_valid && (!act_q || (emit && final_item));
	assign pop = load;
	assign out_valid = out_valid_q;
	assign out_req = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= job.status;
			dated_q <= job.dated;
			sec_q <= to_bcd(7'(job.sec));
			min_q <= to_bcd(7'(job.min));
			hour_q <= to_bcd(7'(job.hour));
			wday_q <= {5'd0, wmod} + 8'd1;
			date_q <= to_bcd(7'(job.day));
			mon_q <= to_bcd(7'(job.month));
			year_q <= to_bcd(job.year_ofs);
		end
		if (emit) begin
			out_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= act_q;
			end
			if (load) begin
				act_q <= 1'b1;
				idx_q <= RA_SEC;
			end else if (emit) begin
				if (final_item) begin
					act_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/ascii_datetime_to_rtc_regs.sv -----
// ascii_datetime_to_rtc_regs: command string to rtc register write requests
// one character accepted per cycle; the parser stalls only while the job queue is full
// a string's job passes the queue, the writer's job registers and the output register
// throughput: one writer request per cycle when not stalled; 1, 3 or 7 per string
// reset: arst_n clears parser state, job queue and output valid flag at once
`default_nettype none
module ascii_datetime_to_rtc_regs #(
	parameter int QUEUE_DEPTH = adrtc_pkg::ADRTC_QUEUE_DEPTH
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   char_valid,
	output logic                  char_stall,
	input  adrtc_pkg::char_req_t  char_req,
	output logic                  reg_valid,
	input  wire                   reg_stall,
	output adrtc_pkg::reg_req_t   reg_req
);
	import adrtc_pkg::*;

	logic accept, push, pop, full, not_empty;
	job_t push_job, head;

	assign char_stall = full;
	assign accept = char_valid && !full;

	adrtc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (char_req),
		.push   (push),
		.job    (push_job)
	);

	adrtc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	adrtc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (not_empty),
		.job       (head),
		.pop       (pop),
		.out_valid (reg_valid),
		.out_stall (reg_stall),
		.out_req   (reg_req)
	);

endmodule
`default_nettype wire

// ----- bench/tb_ascii_datetime_to_rtc_regs.sv -----
// tb_ascii_datetime_to_rtc_regs: self-checking bench for the command string to rtc register encoder
// drives character requests, predicts the bcd register write requests and checks them in order
// depends on adrtc_pkg and ascii_datetime_to_rtc_regs
`timescale 1ns / 1ps
`default_nettype none
module tb_ascii_datetime_to_rtc_regs;
	import adrtc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic [2:0] {
		SCAN_LEAD, SCAN_TIME, SCAN_GAP, SCAN_DATE, HAVE_DATE, HAVE_TIME, HAVE_ERROR
	} scan_phase_e;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      char_valid;
	logic      char_stall;
	char_req_t char_req;
	logic      reg_valid;
	logic      reg_stall = 1'b0;
	reg_req_t  reg_req;

	scan_phase_e scan_phase;
	logic [3:0]  digit_cnt;
	logic [6:0]  hour_v, min_v, sec_v, month_v, day_v;
	logic [13:0] year_v;
	logic [2:0]  fail_status;
	int          month_shift[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

	reg_req_t pending_writes[$];
	int       mismatches = 0;
	int       idle_cycles = 0;
	int       src_idle_pct = 0;
	int       sink_stall_pct = 0;

	ascii_datetime_to_rtc_regs i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_req  (char_req),
		.reg_valid (reg_valid),
		.reg_stall (reg_stall),
		.reg_req   (reg_req)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void clear_scan();
		scan_phase = SCAN_LEAD;
		digit_cnt = '0;
		hour_v = '0;
		min_v = '0;
		sec_v = '0;
		year_v = '0;
		month_v = '0;
		day_v = '0;
		fail_status = ST_OK;
	endfunction

	function automatic void latch_failure(input logic [2:0] st);
		fail_status = st;
		scan_phase = HAVE_ERROR;
	endfunction

	function automatic void close_string();
		if (scan_phase == SCAN_LEAD || scan_phase == SCAN_TIME)
			latch_failure(ST_TIME_DIGIT);
		else if (scan_phase == SCAN_GAP)
			scan_phase = HAVE_TIME;
		else if (scan_phase == SCAN_DATE)
			latch_failure(ST_DATE_DIGIT);
	endfunction

	function automatic void scan_char(input logic [7:0] c);
		logic       is_blank;
		logic       is_digit;
		logic [7:0] dv;
		is_blank = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
		is_digit = (c >= 8'd48 && c <= 8'd57);
		dv = c - 8'd48;
		if (scan_phase >= HAVE_DATE)
			return;
		if (c == 8'd0) begin
			close_string();
			return;
		end
		if (scan_phase == SCAN_LEAD) begin
			if (is_blank)
				return;
			scan_phase = SCAN_TIME;
		end
		if (scan_phase == SCAN_TIME) begin
			if (!is_digit) begin
				latch_failure(ST_TIME_DIGIT);
				return;
			end
			if (digit_cnt < 2)
				hour_v = 7'(hour_v * 10 + dv);
			else if (digit_cnt < 4)
				min_v = 7'(min_v * 10 + dv);
			else
				sec_v = 7'(sec_v * 10 + dv);
			digit_cnt++;
			if (digit_cnt >= 6) begin
				digit_cnt = '0;
				if (hour_v > HOUR_MAX || min_v > MINSEC_MAX || sec_v > MINSEC_MAX)
					latch_failure(ST_TIME_RANGE);
				else
					scan_phase = SCAN_GAP;
			end
			return;
		end
		if (scan_phase == SCAN_GAP) begin
			if (is_blank)
				return;
			scan_phase = SCAN_DATE;
		end
		if (scan_phase == SCAN_DATE) begin
			if (!is_digit) begin
				latch_failure(ST_DATE_DIGIT);
				return;
			end
			if (digit_cnt < 4)
				year_v = 14'(year_v * 10 + dv);
			else if (digit_cnt < 6)
				month_v = 7'(month_v * 10 + dv);
			else
				day_v = 7'(day_v * 10 + dv);
			digit_cnt++;
			if (digit_cnt >= 8) begin
				digit_cnt = '0;
				if (year_v < YEAR_MIN || year_v > YEAR_MAX)
					latch_failure(ST_YEAR_RANGE);
				else if (month_v < 1 || month_v > 12 || day_v < 1 || day_v > 31)
					latch_failure(ST_DAY_RANGE);
				else
					scan_phase = HAVE_DATE;
			end
		end
	endfunction

	function automatic logic [7:0] bcd_byte(input int v);
		return 8'((((v / 10) % 10) << 4) | (v % 10));
	endfunction

	// sakamoto, 1 = sunday
	function automatic int day_of_week(input int y, input int m, input int d);
		int yy;
		yy = (m < 3) ? y - 1 : y;
		return (yy + yy / 4 - yy / 100 + yy / 400 + month_shift[(m - 1) % 12] + d) % 7 + 1;
	endfunction

	function automatic void queue_write(input logic [2:0] st, input logic [2:0] addr,
			input logic [7:0] val);
		reg_req_t w;
		w.status = st;
		w.reg_addr = addr;
		w.reg_value = val;
		w.last_of_run = 1'b0;
		pending_writes.push_back(w);
	endfunction

	function automatic void predict_writes(input char_req_t r);
		scan_char(r.char_code);
		if (!r.is_last)
			return;
		close_string();
		if (scan_phase == HAVE_ERROR) begin
			queue_write(fail_status, RA_SEC, 8'h00);
		end else begin
			queue_write(ST_OK, RA_SEC, bcd_byte(int'(sec_v)) & SEC_MASK);
			queue_write(ST_OK, RA_MIN, bcd_byte(int'(min_v)));
			queue_write(ST_OK, RA_HOUR, bcd_byte(int'(hour_v)) & HOUR_MASK);
			if (scan_phase == HAVE_DATE) begin
				queue_write(ST_OK, RA_WDAY,
					bcd_byte(day_of_week(int'(year_v), int'(month_v), int'(day_v))));
				queue_write(ST_OK, RA_DATE, bcd_byte(int'(day_v)));
				queue_write(ST_OK, RA_MONTH, bcd_byte(int'(month_v)));
				queue_write(ST_OK, RA_YEAR, bcd_byte(int'(year_v) - 2000));
			end
		end
		pending_writes[pending_writes.size() - 1].last_of_run = 1'b1;
		clear_scan();
	endfunction

	task automatic check_write(input reg_req_t got);
		reg_req_t want;
		if (pending_writes.size() == 0) begin
			$error("unexpected write request: addr %0d value %h", got.reg_addr, got.reg_value);
			mismatches++;
			return;
		end
		want = pending_writes.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			mismatches++;
		end
		if (got.reg_addr !== want.reg_addr) begin
			$error("reg_addr: expected %0d, got %0d", want.reg_addr, got.reg_addr);
			mismatches++;
		end
		if (got.reg_value !== want.reg_value) begin
			$error("reg_value: expected %h, got %h", want.reg_value, got.reg_value);
			mismatches++;
		end
		if (got.last_of_run !== want.last_of_run) begin
			$error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && reg_valid && !reg_stall)
			check_write(reg_req);
		reg_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_valid && !char_stall) || (reg_valid && !reg_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// valid stays high after acceptance; an idle gap in the next send_char or stop_sending lowers it
	task automatic send_char(input logic [7:0] c, input logic last);
		char_req_t r;
		r.char_code = c;
		r.is_last = last;
		while ($urandom_range(99) < src_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_req <= r;
		do
			@(posedge clk);
		while (char_stall);
		predict_writes(r);
	endtask

	task automatic stop_sending();
		char_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_writes.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_command(ref logic [7:0] cmd[$]);
		for (int i = 0; i < cmd.size(); i++)
			send_char(cmd[i], i == cmd.size() - 1);
	endtask

	function automatic logic [7:0] blank_char();
		int r;
		r = $urandom_range(5);
		return (r == 5) ? 8'd32 : 8'(9 + r);
	endfunction

	function automatic void push_number(ref logic [7:0] cmd[$], input int val, input int ndig);
		int div;
		div = 1;
		repeat (ndig - 1) div *= 10;
		for (int i = 0; i < ndig; i++) begin
			cmd.push_back(8'(48 + (val / div) % 10));
			div /= 10;
		end
	endfunction

	// mostly well-formed strings, some with bad ranges, junk, zero bytes or cut short
	function automatic void build_command(ref logic [7:0] cmd[$]);
		int keep;
		cmd.delete();
		repeat ($urandom_range(2)) cmd.push_back(blank_char());
		push_number(cmd, ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(23), 2);
		push_number(cmd, ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59), 2);
		push_number(cmd, ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59), 2);
		if ($urandom_range(9) < 7) begin
			repeat ($urandom_range(2)) cmd.push_back(blank_char());
			push_number(cmd, ($urandom_range(9) == 0) ? $urandom_range(9999)
				: $urandom_range(2099, 2000), 4);
			push_number(cmd, ($urandom_range(9) == 0) ? $urandom_range(99)
				: $urandom_range(12, 1), 2);
			push_number(cmd, ($urandom_range(9) == 0) ? $urandom_range(99)
				: $urandom_range(31, 1), 2);
		end
		case ($urandom_range(9))
			0: begin
				cmd.push_back(8'h00);
				repeat ($urandom_range(3)) cmd.push_back(8'($urandom_range(255)));
			end
			1: repeat ($urandom_range(3, 1)) cmd.push_back(8'($urandom_range(255)));
			default: ;
		endcase
		if ($urandom_range(9) == 0)
			cmd[$urandom_range(cmd.size() - 1)] = 8'($urandom_range(255));
		if ($urandom_range(11) == 0) begin
			keep = $urandom_range(cmd.size(), 1);
			while (cmd.size() > keep)
				void'(cmd.pop_back());
		end
	endfunction

	task automatic run_random_strings(input int budget);
		logic [7:0] cmd[$];
		int sent;
		sent = 0;
		while (sent < budget) begin
			build_command(cmd);
			send_command(cmd);
			sent += cmd.size();
		end
	endtask

	task automatic test_directed();
		send_text("235959 20000101");
		send_text("x");
		send_text("240000");
		send_char(8'h00, 1'b1);
	endtask

	task automatic test_pause_until_drained();
		logic [7:0] cmd[$];
		build_command(cmd);
		send_command(cmd);
		stop_sending();
		wait_drained();
		send_text("000000 20991231");
	endtask

	task automatic test_no_idling();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		run_random_strings(83);
	endtask

	task automatic test_sender_idle();
		src_idle_pct = 82;
		sink_stall_pct = 0;
		run_random_strings(83);
	endtask

	task automatic test_receiver_stall();
		src_idle_pct = 0;
		sink_stall_pct = 82;
		run_random_strings(83);
	endtask

	task automatic test_both_idle();
		src_idle_pct = 38;
		sink_stall_pct = 38;
		run_random_strings(83);
	endtask

	initial begin
		arst_n <= 1'b0;
		char_valid <= 1'b0;
		char_req <= '0;
		clear_scan();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pause_until_drained();
		test_no_idling();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();

		stop_sending();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_writes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
